[hdl/robin_hood_hash_set_macros.svh]
// assertion helpers for the hash set
`ifndef ROBIN_HOOD_HASH_SET_MACROS_SVH
`define ROBIN_HOOD_HASH_SET_MACROS_SVH
`ifndef SYNTH
`define RHHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RHHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RHHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RHHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/rhhs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rhhs_pkg;
	localparam logic [1:0] REQ_INSERT   = 2'd0;
	localparam logic [1:0] REQ_REMOVE   = 2'd1;
	localparam logic [1:0] REQ_CONTAINS = 2'd2;
	localparam logic [1:0] REQ_CLEAR    = 2'd3;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_PROBE_RD,
		ST_PROBE_WR,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [2:0] {
		HS_IDLE,
		HS_MIX,
		HS_MUL,
		HS_SUB,
		HS_FIX
	} hash_state_t;
endpackage
`default_nettype wire

[hdl/rhhs_hash.sv]
`timescale 1ns / 1ps
`default_nettype none
module rhhs_hash #(
	parameter int TABLE_SIZE = 256,
	parameter int KEY_BYTES = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [63:0]                   key,
	output logic                               done,
	output logic [$clog2(TABLE_SIZE)-1:0]      home
);
	import rhhs_pkg::*;

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int QSH = 31 + AW;
	localparam logic [2:0] LAST_BYTE = 3'(KEY_BYTES - 1);
	localparam logic [31:0] T_W = 32'(TABLE_SIZE);
	localparam logic [31:0] RECIP = 32'((64'd1 << QSH) / 64'(TABLE_SIZE));

	hash_state_t state_q, state_d;
	logic [63:0]   key_q;
	logic [31:0]   h_q;
	logic [2:0]    byte_q;
	logic [63:0]   prod_q;
	logic [31:0]   rem_q;
	logic [AW-1:0] home_q;
	logic [7:0]    cur_byte;
	logic [31:0]   quot;
	logic [31:0]   rem_fix;

	assign cur_byte = key_q[{byte_q, 3'b000} +: 8];
	assign quot     = 32'(prod_q >> QSH);
	assign rem_fix  = (rem_q >= T_W) ? rem_q - T_W : rem_q;
	assign home     = home_q;

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			HS_IDLE: begin
				state_d = HS_IDLE;
			end
			HS_MIX: begin
				if (byte_q == LAST_BYTE) state_d = HS_MUL;
			end
			HS_MUL: begin
				state_d = HS_SUB;
			end
			HS_SUB: begin
				state_d = HS_FIX;
			end
			HS_FIX: begin
				state_d = HS_IDLE;
				done    = 1'b1;
			end
			default: state_d = HS_IDLE;
		endcase
		if (start) state_d = HS_MIX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= HS_IDLE;
		else state_q <= state_d;
	end

	// bernstein mix one byte a cycle, then modulo by reciprocal multiply,
	// subtract and one correction step
	always_ff @(posedge clk) begin
		if (start) begin
			key_q  <= key;
			h_q    <= '0;
			byte_q <= '0;
		end else begin
			case (state_q)
				HS_MIX: begin
					h_q    <= (h_q << 5) + h_q + 32'(cur_byte);
					byte_q <= byte_q + 3'd1;
				end
				HS_MUL: prod_q <= {32'd0, h_q} * {32'd0, RECIP};
				HS_SUB: rem_q <= h_q - quot * T_W;
				HS_FIX: home_q <= rem_fix[AW-1:0];
				default: h_q <= h_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[hdl/robin_hood_hash_set.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  signals                         direction
// in       in_valid/in_ready, req_type,key  request transfer in
// out      out_valid/out_ready, was_present, status, entry_count  result out
// cfg      cfg_wr_en, cfg_wr_data           fill_limit write
// contains/remove/insert: scan of all TABLE_SIZE slots, then decide, then done
//   insert of a new key then probes slot by slot (read, then write back)
// hashing runs beside the scan
// clear and reset sweep the memory, one slot a cycle
// a finished result waits in the output register; a stalled out side holds the next result
`include "robin_hood_hash_set_macros.svh"
module robin_hood_hash_set #(
	parameter int TABLE_SIZE = 256,
	parameter int KEY_BYTES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [63:0] key,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             was_present,
	output logic             status,
	output logic [8:0]       entry_count,
	input  wire logic        cfg_wr_en,
	input  wire logic [8:0]  cfg_wr_data
);
	import rhhs_pkg::*;

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam int LW = (CW > 9) ? CW : 9;
	localparam int EW = 1 + AW + 64;
	localparam logic [AW:0] T_CNT = (AW+1)'(TABLE_SIZE);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);
	localparam logic [LW-1:0] T_LIM = LW'(TABLE_SIZE);
	localparam logic [63:0] KEY_MASK =
		(KEY_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

	ctrl_state_t state_q, state_d;

	logic [EW-1:0] mem [TABLE_SIZE];
	logic [EW-1:0] rd_data;
	logic [AW-1:0] rd_addr;
	logic          we;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	logic [8:0]    fill_limit_q;
	logic [1:0]    req_q;
	logic [63:0]   key_q;
	logic [63:0]   carry_key_q;
	logic [AW-1:0] carry_dist_q;
	logic [AW-1:0] pos_q;
	logic [AW:0]   sc_q;
	logic [AW-1:0] addr_s1;
	logic          vld_s1;
	logic          found_q;
	logic [AW-1:0] at_q;
	logic [CW-1:0] held_q;
	logic          clr_pend_q;
	logic          full_q;
	logic          home_ok_q;
	logic          out_valid_q, was_q, status_q;
	logic [8:0]    count_q;

	logic          hash_start, hash_done;
	logic [AW-1:0] home;
	logic [LW-1:0] lim_ext, lim_eff, held_ext;

	logic          e_valid;
	logic [AW-1:0] e_dist;
	logic [63:0]   e_key;
	logic          in_xfer;

	assign e_valid = rd_data[EW-1];
	assign e_dist  = rd_data[64 +: AW];
	assign e_key   = rd_data[63:0];

	assign in_xfer    = in_valid && in_ready;
	assign hash_start = in_xfer && (req_type != REQ_CLEAR);
	assign lim_ext    = LW'(fill_limit_q);
	assign lim_eff    = (lim_ext > T_LIM) ? T_LIM : lim_ext;
	assign held_ext   = LW'(held_q);

	rhhs_hash #(.TABLE_SIZE(TABLE_SIZE), .KEY_BYTES(KEY_BYTES)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (key & KEY_MASK),
		.done   (hash_done),
		.home   (home)
	);

	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_addr  = sc_q[AW-1:0];
		we       = 1'b0;
		wr_addr  = sc_q[AW-1:0];
		wr_data  = '0;
		case (state_q)
			ST_SWEEP: begin
				we = 1'b1;
				if (sc_q[AW-1:0] == LAST_SLOT) state_d = clr_pend_q ? ST_DONE : ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = (req_type == REQ_CLEAR) ? ST_SWEEP : ST_SCAN;
			end
			ST_SCAN: begin
				if (sc_q == T_CNT) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (req_q == REQ_REMOVE && found_q) begin
					we      = 1'b1;
					wr_addr = at_q;
					state_d = ST_DONE;
				end else if (req_q == REQ_INSERT && !found_q) begin
					if (held_ext >= lim_eff) state_d = ST_DONE;
					else if (home_ok_q) state_d = ST_PROBE_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PROBE_RD: begin
				rd_addr = pos_q;
				state_d = ST_PROBE_WR;
			end
			ST_PROBE_WR: begin
				wr_addr = pos_q;
				wr_data = {1'b1, carry_dist_q, carry_key_q};
				if (!e_valid) begin
					we      = 1'b1;
					state_d = ST_DONE;
				end else begin
					we      = (e_dist < carry_dist_q);
					state_d = ST_PROBE_RD;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sc_q         <= '0;
			held_q       <= '0;
			fill_limit_q <= 9'd231;
			clr_pend_q   <= 1'b0;
			home_ok_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			full_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) fill_limit_q <= cfg_wr_data;
			if (hash_done) home_ok_q <= 1'b1;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			vld_s1 <= 1'b0;
			case (state_q)
				ST_SWEEP: begin
					sc_q <= sc_q + 1'b1;
					if (sc_q[AW-1:0] == LAST_SLOT) held_q <= '0;
				end
				ST_IDLE: begin
					sc_q       <= '0;
					found_q    <= 1'b0;
					full_q     <= 1'b0;
					home_ok_q  <= 1'b0;
					clr_pend_q <= in_valid && (req_type == REQ_CLEAR);
				end
				ST_SCAN: begin
					if (sc_q != T_CNT) begin
						sc_q   <= sc_q + 1'b1;
						vld_s1 <= 1'b1;
					end
					if (vld_s1 && e_valid && e_key == key_q) found_q <= 1'b1;
				end
				ST_DECIDE: begin
					if (req_q == REQ_REMOVE && found_q && held_q != '0)
						held_q <= held_q - 1'b1;
					if (req_q == REQ_INSERT && !found_q && held_ext >= lim_eff)
						full_q <= 1'b1;
				end
				ST_PROBE_WR: begin
					if (!e_valid) held_q <= held_q + 1'b1;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) out_valid_q <= 1'b1;
				end
				default: sc_q <= sc_q;
			endcase
		end
	end

	// payload side
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q <= req_type;
			key_q <= key & KEY_MASK;
		end
		addr_s1 <= sc_q[AW-1:0];
		if (state_q == ST_SCAN && vld_s1 && e_valid && e_key == key_q) at_q <= addr_s1;
		if (state_q == ST_DECIDE) begin
			pos_q        <= home;
			carry_dist_q <= '0;
			carry_key_q  <= key_q;
		end
		if (state_q == ST_PROBE_WR) begin
			pos_q        <= (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;
			carry_dist_q <= carry_dist_q + 1'b1;
			if (e_valid && e_dist < carry_dist_q) begin
				carry_dist_q <= e_dist + 1'b1;
				carry_key_q  <= e_key;
			end
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			was_q    <= found_q && !clr_pend_q;
			status_q <= full_q ? STATUS_FULL : STATUS_DONE;
			count_q  <= held_ext[8:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign was_present = was_q;
	assign status      = status_q;
	assign entry_count = count_q;

	`RHHS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, held_ext <= T_LIM)
	`RHHS_ASSERT_NEXT(a_busy_after_xfer, clk, arst_n, in_xfer, !in_ready)
	`RHHS_ASSERT_NOW(a_full_not_present, clk, arst_n, out_valid_q && status_q, !was_q)
	`RHHS_ASSERT_NOW(a_no_xfer_in_probe, clk, arst_n, state_q == ST_PROBE_WR || state_q == ST_SWEEP, !in_ready)
endmodule
`default_nettype wire
